[rtl/round_robin_time_slice_scheduler_unit_macros.svh]
// assertion macros for the round-robin time-slice scheduler
// expects signals named clk and rst in the including module
`ifndef ROUND_ROBIN_TIME_SLICE_SCHEDULER_UNIT_MACROS_SVH
`define ROUND_ROBIN_TIME_SLICE_SCHEDULER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define RRTS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define RRTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rrts_pkg.sv]
// shared sizes, action codes and ring control struct for the scheduler
// no dependencies
`timescale 1ns / 1ps

package rrts_pkg;

  localparam int SLOTS = 8;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int ID_W  = 8;
  localparam int LEN_W = 8;

  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

  // action codes
  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // write controls from the scheduler core to the ring store
  typedef struct packed {
    logic             add_en;
    logic [IDX_W-1:0] add_slot;
    logic [ID_W-1:0]  add_id;
    logic [LEN_W-1:0] add_length;
    logic             upd_en;
    logic [IDX_W-1:0] upd_slot;
    logic [LEN_W-1:0] upd_elapsed;
    logic             del_en;
    logic [IDX_W-1:0] del_slot;
    logic [CNT_W-1:0] live;
  } ring_ctrl_t;

endpackage

[rtl/rrts_ring.sv]
// ring store of process entries: append, elapsed update, delete with close-up
// depends on rrts_pkg
`timescale 1ns / 1ps

module rrts_ring (
  input  logic                         clk,
  input  rrts_pkg::ring_ctrl_t         ctrl,
  input  logic [rrts_pkg::IDX_W-1:0]   rd_slot,
  output logic [rrts_pkg::ID_W-1:0]    rd_id,
  output logic [rrts_pkg::LEN_W-1:0]   rd_length,
  output logic [rrts_pkg::LEN_W-1:0]   rd_elapsed
);

  logic [rrts_pkg::ID_W-1:0]  entry_id      [rrts_pkg::SLOTS];
  logic [rrts_pkg::LEN_W-1:0] entry_length  [rrts_pkg::SLOTS];
  logic [rrts_pkg::LEN_W-1:0] entry_elapsed [rrts_pkg::SLOTS];

  for (genvar k = 0; k < rrts_pkg::SLOTS; k++) begin : g_entry
    if (k < rrts_pkg::SLOTS - 1) begin : g_shift
      // entries above a deleted one move down by one
      always_ff @(posedge clk) begin
        if (ctrl.add_en && ctrl.add_slot == rrts_pkg::IDX_W'(k)) begin
          entry_id[k]      <= ctrl.add_id;
          entry_length[k]  <= ctrl.add_length;
          entry_elapsed[k] <= '0;
        end else if (ctrl.del_en && rrts_pkg::IDX_W'(k) >= ctrl.del_slot &&
                     rrts_pkg::CNT_W'(k + 1) < ctrl.live) begin
          entry_id[k]      <= entry_id[k+1];
          entry_length[k]  <= entry_length[k+1];
          entry_elapsed[k] <= entry_elapsed[k+1];
        end else if (ctrl.upd_en && ctrl.upd_slot == rrts_pkg::IDX_W'(k)) begin
          entry_elapsed[k] <= ctrl.upd_elapsed;
        end
      end
    end else begin : g_last
      // top entry has nothing above it to pull down
      always_ff @(posedge clk) begin
        if (ctrl.add_en && ctrl.add_slot == rrts_pkg::IDX_W'(k)) begin
          entry_id[k]      <= ctrl.add_id;
          entry_length[k]  <= ctrl.add_length;
          entry_elapsed[k] <= '0;
        end else if (ctrl.upd_en && ctrl.upd_slot == rrts_pkg::IDX_W'(k)) begin
          entry_elapsed[k] <= ctrl.upd_elapsed;
        end
      end
    end
  end

  assign rd_id      = entry_id[rd_slot];
  assign rd_length  = entry_length[rd_slot];
  assign rd_elapsed = entry_elapsed[rd_slot];

endmodule

[rtl/round_robin_time_slice_scheduler_unit.sv]
// round-robin time-slice scheduler, top level
// depends on rrts_pkg, rrts_ring and round_robin_time_slice_scheduler_unit_macros.svh
//
// usage
//   item channel (item_valid/item_ready): action selects add or tick,
//   run_length is the run time of an added process (ignored on tick)
//   result channel (result_valid/result_ready): one result transaction per
//   item transaction, in order: process_id, elapsed, finished, idle, rejected
// timing
//   an item is decoded, applied to the ring and captured in the result
//   register in the cycle it is accepted; the result shows in the cycle after
//   one item per cycle while the result register is empty or being drained; the ring
//   store update and the serve path (slot select, elapsed increment, compare) settle in the same cycle
// stall
//   item_ready is high while the result register is empty or being drained,
//   so a stalled receiver holds the result and blocks only the next item
// reset
//   synchronous, active high: ring empty, pointer at slot 0, next id 0,
//   result register empty; entry contents are left as they are
`timescale 1ns / 1ps
`include "round_robin_time_slice_scheduler_unit_macros.svh"

module round_robin_time_slice_scheduler_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  logic                        action,
  input  logic [rrts_pkg::LEN_W-1:0]  run_length,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [rrts_pkg::ID_W-1:0]   process_id,
  output logic [rrts_pkg::LEN_W-1:0]  elapsed,
  output logic                        finished,
  output logic                        idle,
  output logic                        rejected
);

  // scheduler state
  logic [rrts_pkg::CNT_W-1:0] live_count, live_count_next;
  logic [rrts_pkg::IDX_W-1:0] current_slot, current_slot_next;
  logic [rrts_pkg::ID_W-1:0]  next_id, next_id_next;

  // served entry and its update
  logic [rrts_pkg::IDX_W-1:0] cur;
  logic [rrts_pkg::ID_W-1:0]  rd_id;
  logic [rrts_pkg::LEN_W-1:0] rd_length;
  logic [rrts_pkg::LEN_W-1:0] rd_elapsed;
  logic [rrts_pkg::LEN_W-1:0] el_inc;
  logic                       done;
  logic [rrts_pkg::CNT_W-1:0] live_less;
  logic [rrts_pkg::CNT_W-1:0] cur_plus;

  // result values for the accepted item
  logic [rrts_pkg::ID_W-1:0]  res_id;
  logic [rrts_pkg::LEN_W-1:0] res_elapsed;
  logic                       res_finished;
  logic                       res_idle;
  logic                       res_rejected;

  logic                 accept;
  rrts_pkg::ring_ctrl_t ctrl;

  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  rrts_ring u_ring (
    .clk        (clk),
    .ctrl       (ctrl),
    .rd_slot    (cur),
    .rd_id      (rd_id),
    .rd_length  (rd_length),
    .rd_elapsed (rd_elapsed)
  );

  // pointer past the end of the ring wraps to the head
  assign cur = (rrts_pkg::CNT_W'(current_slot) >= live_count) ? '0 : current_slot;

  // elapsed count saturates at all ones
  assign el_inc    = (rd_elapsed != '1) ? rd_elapsed + 1'b1 : rd_elapsed;
  assign done      = (el_inc >= rd_length);
  assign live_less = live_count - 1'b1;
  assign cur_plus  = rrts_pkg::CNT_W'(cur) + 1'b1;

  always_comb begin
    ctrl              = '0;
    ctrl.live         = live_count;
    live_count_next   = live_count;
    current_slot_next = current_slot;
    next_id_next      = next_id;
    res_id            = '0;
    res_elapsed       = '0;
    res_finished      = 1'b0;
    res_idle          = 1'b0;
    res_rejected      = 1'b0;
    if (accept) begin
      if (action == rrts_pkg::ACT_ADD) begin
        if (live_count >= rrts_pkg::SLOTS_CNT) begin
          res_rejected = 1'b1;
        end else begin
          // append at the tail with the next sequential id
          ctrl.add_en     = 1'b1;
          ctrl.add_slot   = live_count[rrts_pkg::IDX_W-1:0];
          ctrl.add_id     = next_id;
          ctrl.add_length = run_length;
          live_count_next = live_count + 1'b1;
          next_id_next    = next_id + 1'b1;
          res_id          = next_id;
        end
      end else begin
        if (live_count == '0) begin
          res_idle = 1'b1;
        end else begin
          res_id      = rd_id;
          res_elapsed = el_inc;
          if (done) begin
            // remove served entry, successor slides into its slot
            res_finished      = 1'b1;
            ctrl.del_en       = 1'b1;
            ctrl.del_slot     = cur;
            live_count_next   = live_less;
            current_slot_next = (rrts_pkg::CNT_W'(cur) >= live_less) ? '0 : cur;
          end else begin
            ctrl.upd_en       = 1'b1;
            ctrl.upd_slot     = cur;
            ctrl.upd_elapsed  = el_inc;
            current_slot_next = (cur_plus >= live_count) ? '0
                                : cur_plus[rrts_pkg::IDX_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live_count   <= '0;
      current_slot <= '0;
      next_id      <= '0;
    end else begin
      live_count   <= live_count_next;
      current_slot <= current_slot_next;
      next_id      <= next_id_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      process_id <= res_id;
      elapsed    <= res_elapsed;
      finished   <= res_finished;
      idle       <= res_idle;
      rejected   <= res_rejected;
    end
  end

  // checks
  `RRTS_ASSERT_IMPL(a_count_bound, 1'b1, live_count <= rrts_pkg::SLOTS_CNT,
                    "live count beyond ring size")
  `RRTS_ASSERT_IMPL(a_slot_in_ring, live_count != '0,
                    rrts_pkg::CNT_W'(current_slot) < live_count,
                    "pointer outside live entries")
  `RRTS_ASSERT_NEXT(a_id_advance,
                    accept && action == rrts_pkg::ACT_ADD && live_count < rrts_pkg::SLOTS_CNT,
                    next_id == $past(next_id) + 8'd1,
                    "id did not advance on accepted add")
  `RRTS_ASSERT_NEXT(a_idle_on_empty,
                    accept && action == rrts_pkg::ACT_TICK && live_count == '0,
                    result_valid && idle && live_count == '0,
                    "tick on empty ring not reported idle")
  `RRTS_ASSERT_IMPL(a_one_flag, result_valid, $onehot0({finished, idle, rejected}),
                    "more than one status flag in a result")

endmodule

[test/tb_round_robin_time_slice_scheduler_unit.sv]
// self-checking testbench for round_robin_time_slice_scheduler_unit
// depends on rrts_pkg and the scheduler rtl; predicts every result from its own ring model
`timescale 1ns / 1ps

module tb_round_robin_time_slice_scheduler_unit;

  localparam int STUCK_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 790;
  localparam int ITEM_BUDGET  = 880;

  typedef struct packed {
    logic [rrts_pkg::ID_W-1:0]  pid;
    logic [rrts_pkg::LEN_W-1:0] el;
    logic                       fin;
    logic                       idl;
    logic                       rej;
  } sched_result_t;

  // ring predictor plus queue of results still owed by the block
  class sched_scoreboard;
    logic [rrts_pkg::ID_W-1:0]  slot_pid [rrts_pkg::SLOTS];
    logic [rrts_pkg::LEN_W-1:0] slot_len [rrts_pkg::SLOTS];
    logic [rrts_pkg::LEN_W-1:0] slot_el  [rrts_pkg::SLOTS];
    int                         live;
    int                         cur;
    logic [rrts_pkg::ID_W-1:0]  next_pid;
    sched_result_t              owed_q[$];
    int errors, n_add, n_rej, n_tick, n_fin, n_idle, n_seen;

    function new();
      live = 0;
      cur = 0;
      next_pid = '0;
    endfunction

    function void note_item(logic act, logic [rrts_pkg::LEN_W-1:0] len);
      sched_result_t r;
      logic [rrts_pkg::LEN_W-1:0] e;
      r = '0;
      if (act == rrts_pkg::ACT_ADD) begin
        if (live >= rrts_pkg::SLOTS) begin
          r.rej = 1'b1;
          n_rej++;
        end else begin
          slot_pid[live] = next_pid;
          slot_len[live] = len;
          slot_el[live]  = '0;
          live++;
          r.pid = next_pid;
          next_pid++;
          n_add++;
        end
      end else begin
        n_tick++;
        if (live == 0) begin
          r.idl = 1'b1;
          n_idle++;
        end else begin
          if (cur >= live) cur = 0;
          e = slot_el[cur];
          if (e != '1) e++;
          slot_el[cur] = e;
          r.pid = slot_pid[cur];
          r.el  = e;
          if (e >= slot_len[cur]) begin
            // done: close the gap, pointer stays on the successor
            r.fin = 1'b1;
            n_fin++;
            for (int k = cur; k + 1 < live; k++) begin
              slot_pid[k] = slot_pid[k+1];
              slot_len[k] = slot_len[k+1];
              slot_el[k]  = slot_el[k+1];
            end
            live--;
            if (cur >= live) cur = 0;
          end else begin
            cur++;
            if (cur >= live) cur = 0;
          end
        end
      end
      owed_q.push_back(r);
    endfunction

    function void cmp_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t exp_r;
      n_seen++;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual id %0d elapsed %0d",
                 $time, got.pid, got.el);
        errors++;
        return;
      end
      exp_r = owed_q.pop_front();
      cmp_field("process_id", exp_r.pid, got.pid);
      cmp_field("elapsed", exp_r.el, got.el);
      cmp_field("finished", exp_r.fin, got.fin);
      cmp_field("idle", exp_r.idl, got.idl);
      cmp_field("rejected", exp_r.rej, got.rej);
    endfunction

    function int outstanding();
      return owed_q.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       item_valid = 1'b0;
  logic                       item_ready;
  logic                       action = rrts_pkg::ACT_ADD;
  logic [rrts_pkg::LEN_W-1:0] run_length = '0;
  logic                       result_valid;
  logic                       result_ready = 1'b0;
  logic [rrts_pkg::ID_W-1:0]  process_id;
  logic [rrts_pkg::LEN_W-1:0] elapsed;
  logic                       finished;
  logic                       idle;
  logic                       rejected;

  sched_scoreboard sb = new();

  int items_sent = 0;
  int burst_left = 0;
  int stuck_cycles = 0;

  round_robin_time_slice_scheduler_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .action       (action),
    .run_length   (run_length),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .process_id   (process_id),
    .elapsed      (elapsed),
    .finished     (finished),
    .idle         (idle),
    .rejected     (rejected)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // sender: bursts of random length, random gaps in between
  task automatic send_item(input logic act, input logic [rrts_pkg::LEN_W-1:0] len);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_valid <= 1'b1;
    action     <= act;
    run_length <= len;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.note_item(act, len);
    items_sent++;
  endtask

  task automatic add_proc(input logic [rrts_pkg::LEN_W-1:0] len);
    send_item(rrts_pkg::ACT_ADD, len);
  endtask

  // run_length is don't-care on a tick, so it carries noise
  task automatic tick_once();
    send_item(rrts_pkg::ACT_TICK, rrts_pkg::LEN_W'($urandom_range(0, 255)));
  endtask

  // tick until the ring is empty or the item count reaches the given cap
  task automatic drain_ring(input int cap);
    while (sb.live > 0 && items_sent < cap) tick_once();
  endtask

  // mostly short jobs so the ring turns over, with a thin tail of long ones
  function automatic logic [rrts_pkg::LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 62) return rrts_pkg::LEN_W'(1);
    if (r < 82) return rrts_pkg::LEN_W'($urandom_range(2, 4));
    if (r < 93) return rrts_pkg::LEN_W'($urandom_range(5, 24));
    if (r < 97) return rrts_pkg::LEN_W'($urandom_range(25, 80));
    if (r < 99) return rrts_pkg::LEN_W'($urandom_range(81, 254));
    return $urandom_range(0, 1) ? 8'hFF : 8'h00;
  endfunction

  // receiver: switches between always ready, random, fixed pattern and long stalls
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_hold_left = 0;
  logic rx_hold_high = 1'b0;
  logic [7:0] rx_pattern = 8'b1011_0010;
  int rx_pos = 0;

  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(20, 120);
    end
    rx_mode_left--;
    case (rx_mode)
      0: result_ready <= 1'b1;
      1: result_ready <= ($urandom_range(0, 99) < 65);
      2: begin
        result_ready <= rx_pattern[rx_pos % 8];
        rx_pos++;
      end
      default: begin
        if (rx_hold_left == 0) begin
          rx_hold_high = !rx_hold_high;
          rx_hold_left = rx_hold_high ? $urandom_range(1, 4) : $urandom_range(1, 12);
        end
        rx_hold_left--;
        result_ready <= rx_hold_high;
      end
    endcase
  end

  // result monitor
  always @(posedge clk) begin
    sched_result_t got;
    if (!rst && result_valid && result_ready) begin
      got.pid = process_id;
      got.el  = elapsed;
      got.fin = finished;
      got.idl = idle;
      got.rej = rejected;
      sb.check_result(got);
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles + 1 >= STUCK_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int kind, n, pct;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: tick on an empty ring
    tick_once();
    // zero run length finishes on its first tick
    add_proc(8'h00);
    tick_once();
    // removal mid-ring keeps the pointer on the successor, removal of the last wraps
    add_proc(8'd1);
    add_proc(8'd3);
    add_proc(8'd2);
    repeat (6) tick_once();
    // fill the ring with bit-walking lengths, then an add on a full ring
    add_proc(8'hFF);
    add_proc(8'h01);
    add_proc(8'h02);
    add_proc(8'h04);
    add_proc(8'h08);
    add_proc(8'h10);
    add_proc(8'h20);
    add_proc(8'h40);
    add_proc(8'hAA);
    tick_once();
    tick_once();

    // random part: mixed add and tick traffic with full and empty rings
    while (items_sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        // batch of jobs followed by a run of ticks
        n = $urandom_range(1, 10);
        repeat (n) add_proc(pick_length());
        n = $urandom_range(1, 24);
        repeat (n) tick_once();
      end else if (kind < 7) begin
        pct = 25 * $urandom_range(1, 3);
        n = $urandom_range(5, 30);
        repeat (n) begin
          if ($urandom_range(0, 99) < pct) add_proc(pick_length());
          else tick_once();
        end
      end else if (kind < 9) begin
        // run the ring dry, then tick it empty
        drain_ring(RANDOM_ITEMS);
        n = $urandom_range(1, 2);
        repeat (n) tick_once();
      end else begin
        n = $urandom_range(4, 12);
        repeat (n) begin
          if ($urandom_range(0, 1)) begin
            send_item(rrts_pkg::ACT_ADD, rrts_pkg::LEN_W'($urandom_range(0, 255)));
          end else begin
            tick_once();
          end
        end
      end
    end
    // let the remaining jobs run on so higher elapsed counts show up
    drain_ring(ITEM_BUDGET);
    item_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("summary: %0d items, %0d results, %0d jobs admitted, %0d refused on a full ring",
             items_sent, sb.n_seen, sb.n_add, sb.n_rej);
    $display("summary: %0d ticks, %0d jobs completed, %0d ticks on an empty ring",
             sb.n_tick, sb.n_fin, sb.n_idle);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[round_robin_time_slice_scheduler_unit.f]
+incdir+rtl
rtl/rrts_pkg.sv
rtl/rrts_ring.sv
rtl/round_robin_time_slice_scheduler_unit.sv
test/tb_round_robin_time_slice_scheduler_unit.sv
